// ===== design/rwpe_pkg.sv =====
// rwpe_pkg: shared types and fixed widths of the ring waveform peak envelope block
// no dependencies
`timescale 1ns / 1ps
package rwpe_pkg;

  localparam int QW  = 27;  // divider dividend and quotient width
  localparam int DW  = 17;  // divider divisor and remainder width
  localparam int SW  = 16;  // column stride width
  localparam int OW  = 15;  // window origin and grid start width
  localparam int PRW = 26;  // column times stride product width

  typedef enum logic [1:0] {
    CMD_WRITE,
    CMD_RESTART,
    CMD_WINDOW,
    CMD_RENDER
  } rwpe_cmd_t;

  typedef enum logic {
    REG_ALIGN_LOCK,
    REG_RING_LENGTH
  } rwpe_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WMOD,
    ST_SPAN,
    ST_ALIGN,
    ST_FWD,
    ST_BACK,
    ST_WRAP,
    ST_MUL,
    ST_ADDR,
    ST_RDIV,
    ST_READ,
    ST_DRAIN,
    ST_EMIT
  } rwpe_state_t;

endpackage

// ===== design/rwpe_ram.sv =====
// rwpe_ram: generic simple dual port ram, one write port, one registered read port
// no dependencies
`timescale 1ns / 1ps
module rwpe_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/ring_waveform_peak_envelope.sv =====
// ring_waveform_peak_envelope: sample ring with min/max peak envelope per display column
// depends on rwpe_pkg and rwpe_ram
//
// A write word stores one sample. When its position lies beyond the ring, the position is
// first reduced modulo the ring depth by a reciprocal multiply. A window word takes its
// samples per column from a reciprocal multiply by 1/COLUMNS when its end is not below its
// position. Grid snapping adds one pass of the shared 27-step restoring divider, and the
// wrap of a negative origin adds a second pass. A render word runs one multiply, one
// divider pass for the wrapped start address, then one ring read per cycle on the single
// ram read port; its result waits while the output word is stalled. Renders of columns
// at or beyond COLUMNS return nothing. The ring needs no clearing pass; entries must be
// written before they are rendered.
`timescale 1ns / 1ps
module ring_waveform_peak_envelope #(
  parameter int RING_DEPTH = 16384,
  parameter int COLUMNS    = 620,
  parameter int BASKET     = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  rwpe_pkg::rwpe_cmd_t cmd,
  input  logic [13:0]         position,
  input  logic [14:0]         window_end,
  input  logic signed [15:0]  sample,
  input  logic [9:0]          column,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [9:0]          column_out,
  output logic [14:0]         peak_high,
  output logic signed [15:0]  peak_low,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  rwpe_pkg::rwpe_reg_t cfg_index,
  input  logic [14:0]         cfg_data
);

  import rwpe_pkg::*;

  localparam int AW = $clog2(RING_DEPTH);
  localparam int LW = $clog2(RING_DEPTH + 1);
  localparam int CW = $clog2(BASKET + 1);

  // reciprocal constants for the constant divisions
  localparam int          SP_SH = 16 + $clog2(COLUMNS);
  localparam longint      SP_M  = ((longint'(1) << SP_SH) + longint'(COLUMNS) - 1) /
                                  longint'(COLUMNS);
  localparam logic [17:0] SP_MK = 18'(SP_M);
  localparam int          WM_SH = 14 + $clog2(RING_DEPTH);
  localparam longint      WM_M  = ((longint'(1) << WM_SH) + longint'(RING_DEPTH) - 1) /
                                  longint'(RING_DEPTH);
  localparam logic [15:0] WM_MK = 16'(WM_M);

  rwpe_state_t state, state_next;

  // configuration
  logic          align_lock;
  logic [14:0]   ring_length;
  logic [LW-1:0] len;

  // latched word
  logic [13:0]        win_start;
  logic [14:0]        win_end;
  logic [9:0]         col;
  logic signed [15:0] smp;
  logic [13:0]        wq;

  // window state
  logic          realign_pending;
  logic [OW-1:0] grid_start;
  logic [SW-1:0] grid_step;
  logic [OW-1:0] window_origin;
  logic [SW-1:0] column_stride;
  logic [CW-1:0] read_count;
  logic [SW-1:0] s;

  // render state
  logic [PRW-1:0]     prod;
  logic [AW-1:0]      rd_addr;
  logic [CW-1:0]      issued;
  logic               rd_vld;
  logic [14:0]        hi;
  logic signed [15:0] lo;

  // divider
  logic          div_busy, div_done;
  logic [4:0]    div_cnt;
  logic [QW-1:0] div_q;
  logic [DW-1:0] div_r, div_d;
  logic          div_start;
  logic [QW-1:0] div_dividend;
  logic [DW-1:0] div_divisor;
  logic [DW:0]   div_sh;

  // ram
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [15:0]   ram_wdata;
  logic [15:0]   ram_rdata;

  logic          accept;
  logic          pos_big;
  logic          col_ok;
  logic [OW-1:0] gs_e;
  logic [SW-1:0] gstep_e;
  logic          a_ge;
  logic [OW-1:0] d_up;
  logic [SW-1:0] rem_s;
  logic [SW-1:0] back_t;
  logic          back_ok;
  logic          last_issue;
  logic [LW:0]   addr_inc;
  logic          emit_ok;
  logic [15:0]   span_x;
  logic [33:0]   span_prod;
  logic [29:0]   wm_prod;
  logic [31:0]   wm_rem;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign pos_big   = 32'(position) >= RING_DEPTH;
  assign col_ok    = 32'(column) < COLUMNS;
  assign emit_ok   = !out_valid || out_ready;

  always_comb begin
    if (ring_length == 15'd0) begin
      len = LW'(1);
    end else if (32'(ring_length) > RING_DEPTH) begin
      len = LW'(RING_DEPTH);
    end else begin
      len = LW'(ring_length);
    end
  end

  assign gs_e       = realign_pending ? OW'(win_start) : grid_start;
  assign gstep_e    = realign_pending ? s : grid_step;
  assign a_ge       = OW'(win_start) >= gs_e;
  assign d_up       = OW'(win_start) - gs_e;
  assign rem_s      = SW'(div_r);
  assign back_t     = (rem_s == '0) ? '0 : s - rem_s;
  assign back_ok    = SW'(win_start) >= back_t;
  assign last_issue = (issued + 1'b1) == read_count;
  assign addr_inc   = (LW+1)'(rd_addr) + 1'b1;
  assign span_x     = 16'(17'(win_end) - 17'(win_start) + 17'(COLUMNS));
  assign span_prod  = 34'(span_x) * 34'(SP_MK);
  assign wm_prod    = 30'(position) * 30'(WM_MK);
  assign wm_rem     = 32'(win_start) - 32'(wq) * 32'(RING_DEPTH);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (cmd)
            CMD_WRITE:   state_next = pos_big ? ST_WMOD : ST_IDLE;
            CMD_WINDOW:  state_next = (window_end >= 15'(position)) ? ST_SPAN : ST_ALIGN;
            CMD_RENDER:  state_next = col_ok ? ST_MUL : ST_IDLE;
            default:     state_next = ST_IDLE;
          endcase
        end
      end
      ST_WMOD:  state_next = ST_IDLE;
      ST_SPAN:  state_next = ST_ALIGN;
      ST_ALIGN: begin
        if (align_lock || s != gstep_e) begin
          state_next = ST_IDLE;
        end else if (a_ge) begin
          state_next = (d_up == '0) ? ST_IDLE : ST_FWD;
        end else begin
          state_next = ST_BACK;
        end
      end
      ST_FWD:   if (div_done) state_next = ST_IDLE;
      ST_BACK:  if (div_done) state_next = back_ok ? ST_IDLE : ST_WRAP;
      ST_WRAP:  if (div_done) state_next = ST_IDLE;
      ST_MUL:   state_next = ST_ADDR;
      ST_ADDR:  state_next = ST_RDIV;
      ST_RDIV:  if (div_done) state_next = ST_READ;
      ST_READ:  if (last_issue) state_next = ST_DRAIN;
      ST_DRAIN: state_next = ST_EMIT;
      ST_EMIT:  if (emit_ok) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = DW'(1);
    ram_we       = 1'b0;
    ram_waddr    = AW'(position);
    ram_wdata    = sample;
    case (state)
      ST_IDLE: begin
        if (accept && cmd == CMD_WRITE && !pos_big) begin
          ram_we = 1'b1;
        end
      end
      ST_WMOD: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(wm_rem);
        ram_wdata = smp;
      end
      ST_ALIGN: begin
        if (!align_lock && s == gstep_e) begin
          div_divisor = DW'(s);
          if (a_ge && d_up != '0) begin
            div_start    = 1'b1;
            div_dividend = QW'(d_up - 1'b1);
          end else if (!a_ge) begin
            div_start    = 1'b1;
            div_dividend = QW'(gs_e - OW'(win_start));
          end
        end
      end
      ST_BACK: begin
        if (div_done && !back_ok) begin
          div_start    = 1'b1;
          div_dividend = QW'(back_t - SW'(win_start));
          div_divisor  = DW'(len);
        end
      end
      ST_ADDR: begin
        div_start    = 1'b1;
        div_dividend = QW'(window_origin) + QW'(prod);
        div_divisor  = DW'(len);
      end
      default: ;
    endcase
  end

  // shared restoring divider, one quotient bit per cycle
  assign div_sh = {div_r, div_q[QW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
      div_done <= 1'b0;
      div_cnt  <= '0;
    end else begin
      div_done <= 1'b0;
      if (div_start) begin
        div_busy <= 1'b1;
        div_cnt  <= '0;
        div_q    <= div_dividend;
        div_r    <= '0;
        div_d    <= div_divisor;
      end else if (div_busy) begin
        if (div_sh >= {1'b0, div_d}) begin
          div_r <= DW'(div_sh - {1'b0, div_d});
          div_q <= {div_q[QW-2:0], 1'b1};
        end else begin
          div_r <= DW'(div_sh);
          div_q <= {div_q[QW-2:0], 1'b0};
        end
        div_cnt <= div_cnt + 1'b1;
        if (div_cnt == 5'(QW - 1)) begin
          div_busy <= 1'b0;
          div_done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      align_lock      <= 1'b0;
      ring_length     <= 15'd16384;
      realign_pending <= 1'b1;
      grid_start      <= '0;
      grid_step       <= '0;
      window_origin   <= '0;
      column_stride   <= SW'(1);
      read_count      <= CW'(1);
      out_valid       <= 1'b0;
      rd_vld          <= 1'b0;
    end else begin
      state  <= state_next;
      rd_vld <= (state == ST_READ);

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ALIGN_LOCK:  align_lock  <= cfg_data[0];
          REG_RING_LENGTH: ring_length <= cfg_data;
          default: ;
        endcase
      end

      if (out_valid && out_ready && state != ST_EMIT) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (accept) begin
            win_start <= position;
            win_end   <= window_end;
            col       <= column;
            smp       <= sample;
            wq        <= 14'(wm_prod >> WM_SH);
            s         <= SW'(1);
            if (cmd == CMD_RESTART) begin
              realign_pending <= 1'b1;
            end
          end
        end
        ST_SPAN: begin
          s <= SW'(span_prod >> SP_SH);
        end
        ST_ALIGN: begin
          column_stride <= s;
          read_count    <= (32'(s) <= BASKET) ? CW'(s) : CW'(BASKET);
          window_origin <= OW'(win_start);
          if (!align_lock) begin
            realign_pending <= 1'b0;
            grid_start      <= gs_e;
            grid_step       <= gstep_e;
            if (s == gstep_e && a_ge && d_up == '0) begin
              window_origin <= gs_e;
            end
          end
        end
        ST_FWD: begin
          if (div_done) begin
            window_origin <= OW'(win_start) - OW'(1) - OW'(div_r);
            grid_start    <= OW'(win_start) - OW'(1) - OW'(div_r);
          end
        end
        ST_BACK: begin
          if (div_done && back_ok) begin
            window_origin <= OW'(SW'(win_start) - back_t);
            grid_start    <= OW'(SW'(win_start) - back_t);
          end
        end
        ST_WRAP: begin
          if (div_done) begin
            window_origin <= (div_r == '0) ? '0 : OW'(DW'(len) - div_r);
            grid_start    <= (div_r == '0) ? '0 : OW'(DW'(len) - div_r);
          end
        end
        ST_MUL: begin
          prod <= PRW'(col) * PRW'(column_stride);
          hi   <= '0;
          lo   <= '0;
        end
        ST_RDIV: begin
          if (div_done) begin
            rd_addr <= AW'(div_r);
            issued  <= '0;
          end
        end
        ST_READ: begin
          issued  <= issued + 1'b1;
          rd_addr <= (addr_inc >= (LW+1)'(len)) ? '0 : AW'(addr_inc);
        end
        ST_EMIT: begin
          if (emit_ok) begin
            out_valid  <= 1'b1;
            column_out <= col;
            peak_high  <= hi;
            peak_low   <= lo;
          end
        end
        default: ;
      endcase

      if (rd_vld) begin
        if ($signed(ram_rdata) > $signed({1'b0, hi})) begin
          hi <= 15'(ram_rdata);
        end
        if ($signed(ram_rdata) < lo) begin
          lo <= $signed(ram_rdata);
        end
      end
    end
  end

  rwpe_ram #(
    .WIDTH(16),
    .DEPTH(RING_DEPTH)
  ) u_ring (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(rd_addr),
    .rdata(ram_rdata)
  );

endmodule

// ===== design/rwpe_check.sv =====
// rwpe_check: port level assertions for ring_waveform_peak_envelope
// depends on rwpe_pkg; bound to the top level below
`timescale 1ns / 1ps
module rwpe_check #(
  parameter int COLUMNS = 620
) (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input rwpe_pkg::rwpe_cmd_t cmd,
  input logic [13:0]         position,
  input logic [14:0]         window_end,
  input logic signed [15:0]  sample,
  input logic [9:0]          column,
  input logic                out_valid,
  input logic                out_ready,
  input logic [9:0]          column_out,
  input logic [14:0]         peak_high,
  input logic signed [15:0]  peak_low,
  input logic                cfg_valid,
  input logic                cfg_ready,
  input rwpe_pkg::rwpe_reg_t cfg_index,
  input logic [14:0]         cfg_data
);

  import rwpe_pkg::*;

  // stalled word stays valid with its column and low peak held
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(column_out) && $stable(peak_low))
    else $error("output word dropped or changed while stalled");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  a_low_sign: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> peak_low[15] || peak_low == 16'sd0)
    else $error("positive low peak");

  a_col_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> 32'(column_out) < COLUMNS)
    else $error("column out of range");

endmodule

bind ring_waveform_peak_envelope rwpe_check #(.COLUMNS(COLUMNS)) u_rwpe_check (.*);

// ===== tb/tb_top.sv =====
// tb_top: self-checking bench for ring_waveform_peak_envelope, a directed table then random
// phases over several register settings, every render result checked against a local envelope
// predictor or a directed expected value; depends on rwpe_pkg and ring_waveform_peak_envelope
`timescale 1ns / 1ps
module tb_top;
  import rwpe_pkg::*;

  localparam int DEPTH = 16384;
  localparam int NCOL  = 620;
  localparam int BSK   = 64;
  localparam int LIMIT = 2000000;

  typedef struct packed {
    logic [9:0]         col;
    logic [14:0]        hi;
    logic signed [15:0] lo;
  } env_t;

  typedef struct {
    rwpe_cmd_t   c;
    int          pos;
    int          wend;
    int          smp;
    int          col;
    bit          typed;
    env_t        env;
  } row_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  rwpe_cmd_t          cmd;
  logic [13:0]        position;
  logic [14:0]        window_end;
  logic signed [15:0] sample;
  logic [9:0]         column;
  logic               out_valid;
  logic               out_ready;
  logic [9:0]         column_out;
  logic [14:0]        peak_high;
  logic signed [15:0] peak_low;
  logic               cfg_valid;
  logic               cfg_ready;
  rwpe_reg_t          cfg_index;
  logic [14:0]        cfg_data;

  ring_waveform_peak_envelope u_top (.*);

  // predictor state
  logic signed [15:0] ring_img [DEPTH];
  bit                 written_img [DEPTH];
  bit                 pend;
  int unsigned        gstart, gstep, origin, stride, rcount, rlen;
  bit                 lock;

  env_t envelope_q[$];
  int   errors;
  int   cycles;
  int   n_render, n_window;
  bit   hold_req;
  int   burst_left;

  initial begin
    clk = 0;
    forever begin
      #5 clk = 1;
      #5 clk = 0;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic int unsigned ring_len();
    if (rlen < 1) return 1;
    if (rlen > DEPTH) return DEPTH;
    return rlen;
  endfunction

  function automatic void window_setup(int unsigned a, int unsigned b);
    int unsigned s, d, k, r, len;
    int org;
    s = 1;
    org = a;
    if (b >= a) s = (b - a + NCOL) / NCOL;
    if (s < 1) s = 1;
    stride = s;
    rcount = (s <= BSK) ? s : BSK;
    if (!lock) begin
      if (pend) begin
        gstart = a;
        gstep = s;
        pend = 0;
      end
      if (s == gstep) begin
        if (a >= gstart) begin
          d = a - gstart;
          k = (d == 0) ? 0 : (d - 1) / s;
          org = gstart + k * s;
        end else begin
          d = gstart - a;
          k = (d + s - 1) / s;
          org = int'(gstart) - int'(k * s);
          if (org < 0) begin
            len = ring_len();
            r = (-org) % len;
            org = r ? len - r : 0;
          end
        end
        gstart = org & 32'h7fff;
      end
    end
    origin = org & 32'h7fff;
  endfunction

  // first unwritten entry in a column's group, or -1
  function automatic int group_gap(int col);
    int unsigned len, addr;
    len = ring_len();
    addr = (origin % len + (col * stride) % len) % len;
    for (int j = 0; j < rcount; j++) begin
      if (!written_img[addr]) return int'(addr);
      addr = addr + 1;
      if (addr >= len) addr = 0;
    end
    return -1;
  endfunction

  function automatic bit envelope_predict(rwpe_cmd_t c, int pos, int wend, int smp, int col,
                                          output env_t e);
    int unsigned len, addr;
    int hi, lo, v;
    e = '0;
    case (c)
      CMD_WRITE: begin
        ring_img[pos % DEPTH] = smp[15:0];
        written_img[pos % DEPTH] = 1;
        return 0;
      end
      CMD_RESTART: begin
        pend = 1;
        return 0;
      end
      CMD_WINDOW: begin
        window_setup(pos, wend);
        return 0;
      end
      default: begin
        if (col >= NCOL) return 0;
        len = ring_len();
        addr = (origin % len + (col * stride) % len) % len;
        hi = 0;
        lo = 0;
        for (int j = 0; j < rcount; j++) begin
          v = ring_img[addr];
          if (v > hi) hi = v;
          else if (v < lo) lo = v;
          addr = addr + 1;
          if (addr >= len) addr = 0;
        end
        e.col = 10'(col);
        e.hi = 15'(hi);
        e.lo = 16'(lo);
        return 1;
      end
    endcase
  endfunction

  // one word on the input channel, bursts with random gaps when paced
  task automatic send_word(rwpe_cmd_t c, int pos, int wend, int smp, int col,
                           bit typed = 0, env_t te = '0, bit paced = 1);
    env_t e;
    bit has;
    in_valid <= 1;
    cmd <= c;
    position <= 14'(pos);
    window_end <= 15'(wend);
    sample <= 16'(smp);
    column <= 10'(col);
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    has = envelope_predict(c, pos, wend, smp, col, e);
    if (c == CMD_RENDER) n_render++;
    if (c == CMD_WINDOW) n_window++;
    if (has) envelope_q.push_back(typed ? te : e);
    if (paced) begin
      burst_left--;
      if (burst_left <= 0) begin
        burst_left = $urandom_range(1, 24);
        if ($urandom_range(0, 2) != 0) begin
          in_valid <= 0;
          repeat ($urandom_range(1, 12)) @(posedge clk);
        end
      end
    end
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (envelope_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic reg_write(rwpe_reg_t idx, int val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= 15'(val);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    if (idx == REG_ALIGN_LOCK) lock = val[0];
    else rlen = val & 32'h7fff;
  endtask

  // result checker
  always @(posedge clk) begin
    env_t e;
    if (!rst && out_valid && out_ready) begin
      if (envelope_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result col=%0d hi=%0d lo=%0d", column_out, peak_high, peak_low);
      end else begin
        e = envelope_q.pop_front();
        if (e.col !== column_out || e.hi !== peak_high || e.lo !== peak_low) begin
          errors++;
          if (errors <= 10)
            $display("mismatch exp col=%0d hi=%0d lo=%0d got col=%0d hi=%0d lo=%0d",
                     e.col, e.hi, e.lo, column_out, peak_high, peak_low);
        end
      end
    end
  end

  // receiver stalls, plus one long hold-off on request
  initial begin
    int pct, seg;
    out_ready = 0;
    @(negedge rst);
    forever begin
      if (hold_req) begin
        out_ready <= 0;
        repeat (3000) @(posedge clk);
        hold_req = 0;
      end else begin
        pct = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(10, 70);
        seg = $urandom_range(16, 96);
        repeat (seg) begin
          @(posedge clk);
          out_ready <= ($urandom_range(1, 100) > pct);
        end
      end
    end
  end

  row_t rows[$];

  function automatic env_t mk(int c, int h, int l);
    env_t e;
    e.col = 10'(c);
    e.hi = 15'(h);
    e.lo = 16'(l);
    return e;
  endfunction

  function automatic row_t rw(rwpe_cmd_t c, int pos, int wend, int smp, int col,
                              bit typed = 0, env_t e = '0);
    row_t r;
    r.c = c;
    r.pos = pos;
    r.wend = wend;
    r.smp = smp;
    r.col = col;
    r.typed = typed;
    r.env = e;
    return r;
  endfunction

  task automatic random_word();
    int a, span, k, c, miss, tries;
    k = $urandom_range(0, 99);
    if (k < 20) begin
      send_word(CMD_WRITE, $urandom_range(0, DEPTH - 1), 0, $urandom_range(0, 65535), 0);
    end else if (k < 24) begin
      send_word(CMD_RESTART, $urandom, $urandom, $urandom, $urandom);
    end else if (k < 38) begin
      a = $urandom_range(0, DEPTH - 1);
      case ($urandom_range(0, 4))
        0: span = $urandom_range(0, NCOL);
        1: span = $urandom_range(NCOL, NCOL * 8);
        2: span = $urandom_range(0, 32767);
        3: span = -$urandom_range(1, 200);
        default: span = NCOL * $urandom_range(1, 4) - 1;
      endcase
      if (a + span > 32767) span = 32767 - a;
      if (a + span < 0) span = -a;
      send_word(CMD_WINDOW, a, a + span, $urandom, $urandom_range(0, 1023));
    end else if ($urandom_range(0, 19) == 0) begin
      send_word(CMD_RENDER, $urandom, $urandom, $urandom, $urandom_range(NCOL, 1023));
    end else begin
      // render only fully written groups, else fill one missing entry
      c = $urandom_range(0, NCOL - 1);
      miss = group_gap(c);
      tries = 0;
      while (miss >= 0 && tries < 16) begin
        c = $urandom_range(0, NCOL - 1);
        miss = group_gap(c);
        tries++;
      end
      if (miss < 0) send_word(CMD_RENDER, $urandom, $urandom, $urandom, c);
      else send_word(CMD_WRITE, miss, 0, $urandom_range(0, 65535), 0);
    end
  endtask

  int lock_set[8] = '{0, 1, 0, 1, 0, 0, 1, 0};
  int len_set[8]  = '{16384, 16384, 1, 64, 0, 32767, 1000, 16383};
  int fill_lo[5]  = '{0, 102, 328, 619, 1892};
  int fill_hi[5]  = '{91, 102, 354, 619, 1894};

  initial begin
    errors = 0;
    cycles = 0;
    n_render = 0;
    n_window = 0;
    hold_req = 0;
    burst_left = 8;
    rst = 1;
    in_valid = 0;
    cmd = CMD_WRITE;
    position = 0;
    window_end = 0;
    sample = 0;
    column = 0;
    cfg_valid = 0;
    cfg_index = REG_ALIGN_LOCK;
    cfg_data = 0;
    pend = 1;
    gstart = 0;
    gstep = 0;
    origin = 0;
    stride = 1;
    rcount = 1;
    lock = 0;
    rlen = 16384;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // fill the entries that the directed renders read, apart from entry 1895
    foreach (fill_lo[f])
      for (int i = fill_lo[f]; i <= fill_hi[f]; i++)
        send_word(CMD_WRITE, i, 0, $urandom_range(0, 65535), 0, 0, '0, 0);

    rows.push_back(rw(CMD_WRITE, 0, 0, 32767, 0));
    rows.push_back(rw(CMD_WRITE, 1, 0, -32768, 0));
    rows.push_back(rw(CMD_WRITE, 16383, 0, -1, 0));
    rows.push_back(rw(CMD_WINDOW, 0, 0, 0, 0));
    rows.push_back(rw(CMD_RENDER, 0, 0, 0, 0, 1, mk(0, 32767, 0)));
    rows.push_back(rw(CMD_RENDER, 0, 0, 0, 1, 1, mk(1, 0, -32768)));
    rows.push_back(rw(CMD_RENDER, 0, 0, 0, 619));
    rows.push_back(rw(CMD_RENDER, 0, 0, 0, 620));
    rows.push_back(rw(CMD_RENDER, 0, 0, 0, 1023));
    rows.push_back(rw(CMD_WINDOW, 100, 50, 0, 0));
    rows.push_back(rw(CMD_RENDER, 0, 0, 0, 3));
    rows.push_back(rw(CMD_RESTART, 0, 0, 0, 0));
    rows.push_back(rw(CMD_WINDOW, 5, 5 + 3 * NCOL - 1, 0, 0));
    rows.push_back(rw(CMD_WINDOW, 1, 1 + 3 * NCOL - 1, 0, 0));
    rows.push_back(rw(CMD_RENDER, 0, 0, 0, 0));
    rows.push_back(rw(CMD_WINDOW, 40, 40 + 3 * NCOL - 1, 0, 0));
    rows.push_back(rw(CMD_RENDER, 0, 0, 0, 618));
    rows.push_back(rw(CMD_WINDOW, 0, 32767, 0, 0));
    rows.push_back(rw(CMD_RENDER, 0, 0, 0, 619));
    rows.push_back(rw(CMD_WINDOW, 16383, 32767, 0, 0));
    rows.push_back(rw(CMD_RENDER, 0, 0, 0, 619));
    rows.push_back(rw(CMD_RESTART, 16383, 32767, -1, 1023));
    rows.push_back(rw(CMD_WINDOW, 16383, 16383, 0, 0));
    rows.push_back(rw(CMD_RENDER, 0, 0, 0, 0, 1, mk(0, 0, -1)));
    foreach (rows[i])
      send_word(rows[i].c, rows[i].pos, rows[i].wend, rows[i].smp, rows[i].col,
                rows[i].typed, rows[i].env);
    drain();

    foreach (lock_set[p]) begin
      reg_write(REG_ALIGN_LOCK, lock_set[p]);
      reg_write(REG_RING_LENGTH, len_set[p]);
      if (p == 2) hold_req = 1;
      repeat (105) random_word();
      drain();
    end

    $display("covered %0d renders and %0d windows over %0d register settings",
             n_render, n_window, 8);
    $display("lock on and off, ring lengths from 0 to 32767, one long output hold-off");
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d mismatches", errors);
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/rwpe_pkg.sv
design/rwpe_ram.sv
design/ring_waveform_peak_envelope.sv
design/rwpe_check.sv
tb/tb_top.sv
